FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/llst_pkg.sv
// ----------------------------------------------------------------------------
// llst_pkg
// Types and constants shared by the server table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llst_pkg;

    localparam int DEFAULT_ENTRIES = 16;

    localparam logic [15:0] LOAD_MAX = 16'hFFFF;

    localparam logic REQ_SYNC   = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_SELECTED = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [15:0] server_id;
        logic [15:0] server_kind;
        logic [15:0] load_value;
        logic [15:0] conn_handle;
        logic [15:0] kind_mask;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] chosen_id;
        logic [15:0] chosen_kind;
        logic [15:0] chosen_load;
        logic [15:0] chosen_handle;
    } rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] kind;
        logic [15:0] load;
        logic [15:0] handle;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_valid;
    } mem_ctl_t;

endpackage

FILE: rtl/llst_mem.sv
// ----------------------------------------------------------------------------
// llst_mem
// Entry storage with one shared read/write port and per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llst_mem #(
    parameter int ENTRIES = llst_pkg::DEFAULT_ENTRIES
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  llst_pkg::mem_ctl_t                            ctl,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] addr,
    input  llst_pkg::entry_t                              wr_data,
    output llst_pkg::entry_t                              rd_data,
    output logic                                          rd_valid
);

    llst_pkg::entry_t mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    llst_pkg::entry_t   rd_data_reg;
    logic               rd_valid_reg;

    // The valid bits are cleared by reset; the entry words are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en && ctl.set_valid)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg  <= mem[addr];
            rd_valid_reg <= valid_reg[addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

FILE: rtl/llst_ctrl.sv
// ----------------------------------------------------------------------------
// llst_ctrl
// Request sequencer: scans the table one entry per cycle through a shared
// key comparator, then writes back at most one entry and builds the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module llst_ctrl #(
    parameter int ENTRIES = llst_pkg::DEFAULT_ENTRIES
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          req_valid,
    output logic                                          req_stall,
    input  llst_pkg::req_t                                req,
    output logic                                          res_valid,
    input  logic                                          res_stall,
    output llst_pkg::rsp_t                                res,
    output llst_pkg::mem_ctl_t                            mem_ctl,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] mem_addr,
    output llst_pkg::entry_t                              mem_wr_data,
    input  llst_pkg::entry_t                              mem_rd_data,
    input  logic                                          mem_rd_valid
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    llst_pkg::req_t    req_reg, req_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     eidx_reg, eidx_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     hit_idx_reg, hit_idx_next;
    llst_pkg::entry_t  hit_ent_reg, hit_ent_next;
    logic              free_reg, free_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    llst_pkg::rsp_t    rsp_reg, rsp_next;

    logic [31:0]       key_a;
    logic [31:0]       key_b;
    logic              key_lt;
    logic              key_eq;
    logic [15:0]       load_inc;

    // Shared comparator. A sync request compares identifiers for equality,
    // a select request orders entries by load and then by identifier.
    always_comb
    begin
        if (req_reg.req_type == llst_pkg::REQ_SYNC)
        begin
            key_a = {16'd0, mem_rd_data.id};
            key_b = {16'd0, req_reg.server_id};
        end
        else
        begin
            key_a = {mem_rd_data.load, mem_rd_data.id};
            key_b = {hit_ent_reg.load, hit_ent_reg.id};
        end
        key_lt = key_a < key_b;
        key_eq = key_a == key_b;
    end

    assign load_inc = (hit_ent_reg.load == llst_pkg::LOAD_MAX) ? llst_pkg::LOAD_MAX
                                                              : hit_ent_reg.load + 16'd1;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        eidx_next     = eidx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ent_next  = hit_ent_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        rsp_next      = rsp_reg;
        mem_ctl       = '0;
        mem_addr      = cnt_reg[AW-1:0];
        mem_wr_data   = hit_ent_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle; evaluate the word read last cycle.
                if (cnt_reg != CNT_END)
                begin
                    mem_ctl.rd_en = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    eidx_next     = cnt_reg[AW-1:0];
                    pend_next     = 1'b1;
                end
                else if (pend_reg)
                begin
                    state_next = S_WRITE;
                end

                if (pend_reg)
                begin
                    if (req_reg.req_type == llst_pkg::REQ_SYNC)
                    begin
                        if (mem_rd_valid && key_eq && !hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = eidx_reg;
                            hit_ent_next = mem_rd_data;
                        end
                        if (!mem_rd_valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = eidx_reg;
                        end
                    end
                    else if (mem_rd_valid && ((mem_rd_data.kind & req_reg.kind_mask) != 16'd0)
                             && (!hit_reg || key_lt))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = eidx_reg;
                        hit_ent_next = mem_rd_data;
                    end
                end
            end
            S_WRITE:
            begin
                rsp_next   = '0;
                state_next = S_DONE;
                if (req_reg.req_type == llst_pkg::REQ_SYNC)
                begin
                    if (hit_reg)
                    begin
                        mem_ctl.wr_en      = 1'b1;
                        mem_addr           = hit_idx_reg;
                        mem_wr_data.id     = hit_ent_reg.id;
                        mem_wr_data.kind   = hit_ent_reg.kind;
                        mem_wr_data.load   = req_reg.load_value;
                        mem_wr_data.handle = req_reg.conn_handle;
                        rsp_next.status    = llst_pkg::ST_UPDATED;
                    end
                    else if (free_reg)
                    begin
                        mem_ctl.wr_en      = 1'b1;
                        mem_ctl.set_valid  = 1'b1;
                        mem_addr           = free_idx_reg;
                        mem_wr_data.id     = req_reg.server_id;
                        mem_wr_data.kind   = req_reg.server_kind;
                        mem_wr_data.load   = req_reg.load_value;
                        mem_wr_data.handle = req_reg.conn_handle;
                        rsp_next.status    = llst_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        rsp_next.status = llst_pkg::ST_FULL;
                    end
                end
                else if (hit_reg)
                begin
                    mem_ctl.wr_en          = 1'b1;
                    mem_addr               = hit_idx_reg;
                    mem_wr_data.load       = load_inc;
                    rsp_next.status        = llst_pkg::ST_SELECTED;
                    rsp_next.chosen_id     = hit_ent_reg.id;
                    rsp_next.chosen_kind   = hit_ent_reg.kind;
                    rsp_next.chosen_load   = load_inc;
                    rsp_next.chosen_handle = hit_ent_reg.handle;
                end
                else
                begin
                    rsp_next.status = llst_pkg::ST_NONE;
                end
            end
            S_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        eidx_reg     <= eidx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = rsp_reg;

    `ASSERT_CLK(a_write_only_in_write, mem_ctl.wr_en |-> state_reg == S_WRITE, "table write outside write step")
    `ASSERT_CLK(a_eval_follows_read, pend_reg |-> $past(mem_ctl.rd_en), "evaluation without a preceding read")
    `ASSERT_CLK(a_insert_only_on_miss, mem_ctl.set_valid |-> (mem_ctl.wr_en && !hit_reg && free_reg), "insert while entry matched or no free slot")

endmodule

FILE: rtl/least_loaded_server_table.sv
// ----------------------------------------------------------------------------
// least_loaded_server_table
// Server table with sync (update or insert) and least-loaded select requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Usage: requests arrive on the req channel (req_valid, req_stall, req) and
// responses leave on the rsp channel (rsp_valid, rsp_stall, rsp). A transfer
// takes place at a rising clock edge where valid is high and stall is low.
// Every request yields exactly one response, in request order.
//
// The sequencer walks the entry memory through its single port, one entry
// per cycle, with one comparator shared by all entries. A request passes
// through S_SCAN, which reads every entry and covers the read latency, then
// S_WRITE for the write-back, S_DONE handing the response to the output
// register, and S_IDLE before the next request can be taken. req_stall is
// high while a request is in progress.
//
// Reset clears all valid bits at once, so the table is empty right after
// reset with no clearing pass. The output register lets the next request
// start while a response waits; if the receiver keeps stalling, the finished
// response is held in the sequencer and new requests are stalled.

module least_loaded_server_table #(
    parameter int TABLE_ENTRIES = llst_pkg::DEFAULT_ENTRIES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  llst_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output llst_pkg::rsp_t rsp
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    llst_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      mem_addr;
    llst_pkg::entry_t   mem_wr_data;
    llst_pkg::entry_t   mem_rd_data;
    logic               mem_rd_valid;

    logic               res_valid;
    logic               res_stall;
    llst_pkg::rsp_t     res;

    logic               rsp_valid_reg, rsp_valid_next;
    llst_pkg::rsp_t     rsp_reg, rsp_next;

    llst_mem #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .addr     (mem_addr),
        .wr_data  (mem_wr_data),
        .rd_data  (mem_rd_data),
        .rd_valid (mem_rd_valid)
    );

    llst_ctrl #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_data  (mem_rd_data),
        .mem_rd_valid (mem_rd_valid)
    );

    // The output register can take a new response when it is empty or when
    // its current response transfers in this cycle.
    assign res_stall = rsp_valid_reg && rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && !res_stall)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
